// ===== design/picp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// picp_pkg
// Shared types and constants for the convex polyhedron point test.
// ----------------------------------------------------------------------------
package picp_pkg;

    localparam int unsigned MaxFacesDefault = 64;
    localparam int unsigned FracBitsDefault = 16;

    typedef enum logic [1:0] {
        FUNC_ROW  = 2'd0,
        FUNC_BOX  = 2'd1,
        FUNC_FACE = 2'd2,
        FUNC_TEST = 2'd3
    } t_func;

    typedef struct packed {
        logic [1:0]         func;
        logic [5:0]         slot;
        logic signed [31:0] val0;
        logic signed [31:0] val1;
        logic signed [31:0] val2;
        logic signed [31:0] val3;
        logic signed [31:0] val4;
        logic signed [31:0] val5;
        logic               flipped;
    } t_req;

    typedef struct packed {
        logic inside_res;
        logic in_box;
    } t_res;

endpackage

// ===== design/picp_face_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// picp_face_mem
// Face store: normal, vertex and flipped mark per face, registered read.
// ----------------------------------------------------------------------------
module picp_face_mem
    import picp_pkg::*;
#(
    parameter int unsigned MAX_FACES = MaxFacesDefault,
    parameter int unsigned AW        = $clog2(MAX_FACES)
) (
    input  logic           i_clk,
    input  logic           i_we,
    input  logic [AW-1:0]  i_waddr,
    input  logic [192:0]   i_wdata,
    input  logic [AW-1:0]  i_raddr,
    output logic [192:0]   o_rdata
);

    logic [192:0] r_mem [MAX_FACES];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== design/point_in_convex_polyhedron.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_in_convex_polyhedron
// Box check, transform to model space and half-space test over stored faces.
//
// Channel | Direction | Handshake
// request | in        | i_req on start while !busy
// config  | in        | i_cfg_data on i_cfg_valid && o_cfg_ready
// result  | out       | o_res with o_res_strobe, one cycle
//
// Loads do not raise busy. A test holds busy for a box state, the transform
// (multiply and sum per row), a face state over the active faces, a drain
// state and a closing state; a point outside the box skips from the box
// state to the closing state. The strobe follows in the next cycle.
// Reset clears control state; stored entries are undefined until loaded.
// The result cannot be stalled; busy holds requests off during a test.
// ----------------------------------------------------------------------------
module point_in_convex_polyhedron
    import picp_pkg::*;
#(
    parameter int unsigned MAX_FACES = MaxFacesDefault,
    parameter int unsigned FRAC_BITS = FracBitsDefault
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  t_req       i_req,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [6:0] i_cfg_data,
    output logic       o_res_strobe,
    output t_res       o_res
);

    localparam int unsigned AW = $clog2(MAX_FACES);
    localparam int unsigned CW = AW + 1;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_BOX  = 7'b0000010,
        S_MUL  = 7'b0000100,
        S_SUM  = 7'b0001000,
        S_FACE = 7'b0010000,
        S_DOT  = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic [6:0] r_pc;
    logic signed [31:0] r_rows [12];
    logic signed [31:0] r_box [6];
    logic signed [31:0] r_p [3];
    logic signed [31:0] r_mp [3];
    logic [1:0] r_row;
    logic signed [63:0] r_prod [3];
    logic [CW-1:0] r_fidx, r_nact;
    logic r_inside, r_pend;
    logic signed [65:0] r_dp [3];
    logic r_dv, r_fl;

    logic [192:0] w_wdata, w_rdata;
    logic w_we;

    assign busy = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_we = start && !busy && i_req.func == FUNC_FACE
                  && (32'(i_req.slot) < MAX_FACES);
    assign w_wdata = {i_req.flipped, i_req.val0, i_req.val1, i_req.val2,
                      i_req.val3, i_req.val4, i_req.val5};

    picp_face_mem #(.MAX_FACES(MAX_FACES), .AW(AW)) u_mem (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(AW'(i_req.slot)),
        .i_wdata(w_wdata), .i_raddr(r_fidx[AW-1:0]), .o_rdata(w_rdata)
    );

    logic in_box_c;
    always_comb begin
        in_box_c = 1'b1;
        for (int i = 0; i < 3; i++) begin
            if (r_p[i] < r_box[i] || r_p[i] > r_box[3+i]) in_box_c = 1'b0;
        end
    end

    logic signed [67:0] sum_c;
    logic signed [67:0] sh_c;
    logic signed [31:0] sat_c;
    always_comb begin
        sum_c = 68'(r_prod[0]) + 68'(r_prod[1]) + 68'(r_prod[2])
              + (68'(r_rows[{r_row, 2'd3}]) <<< FRAC_BITS);
        sh_c = sum_c >>> FRAC_BITS;
        if (sh_c > 68'sh7FFFFFFF) sat_c = 32'sh7FFFFFFF;
        else if (sh_c < -68'sh80000000) sat_c = -32'sh80000000;
        else sat_c = sh_c[31:0];
    end

    logic signed [67:0] dot_c;
    assign dot_c = 68'(r_dp[0]) + 68'(r_dp[1]) + 68'(r_dp[2]);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (start && i_req.func == FUNC_TEST) n_state = S_BOX;
            S_BOX:  n_state = in_box_c ? S_MUL : S_DONE;
            S_MUL:  n_state = S_SUM;
            S_SUM:  n_state = (r_row == 2'd2) ? S_FACE : S_MUL;
            S_FACE: if (r_fidx == r_nact) n_state = S_DOT;
            S_DOT:  if (!r_pend && !r_dv) n_state = S_DONE;
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pc <= '0;
            r_pend <= 1'b0;
            r_dv <= 1'b0;
            o_res_strobe <= 1'b0;
        end else begin
            r_state <= n_state;
            o_res_strobe <= 1'b0;
            if (i_cfg_valid) r_pc <= i_cfg_data;
            r_pend <= (r_state == S_FACE) && (r_fidx != r_nact);
            r_dv <= r_pend;
            if (r_state == S_DONE) o_res_strobe <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            unique case (t_func'(i_req.func))
                FUNC_ROW: if (i_req.slot < 6'd3) begin
                    r_rows[{i_req.slot[1:0], 2'd0}] <= i_req.val0;
                    r_rows[{i_req.slot[1:0], 2'd1}] <= i_req.val1;
                    r_rows[{i_req.slot[1:0], 2'd2}] <= i_req.val2;
                    r_rows[{i_req.slot[1:0], 2'd3}] <= i_req.val3;
                end
                FUNC_BOX: begin
                    r_box[0] <= i_req.val0; r_box[1] <= i_req.val1;
                    r_box[2] <= i_req.val2; r_box[3] <= i_req.val3;
                    r_box[4] <= i_req.val4; r_box[5] <= i_req.val5;
                end
                FUNC_FACE: ;
                FUNC_TEST: begin
                    r_p[0] <= i_req.val0; r_p[1] <= i_req.val1;
                    r_p[2] <= i_req.val2;
                end
                default: ;
            endcase
        end
        case (r_state)
            S_BOX: begin
                r_row <= 2'd0;
                r_inside <= 1'b1;
                r_fidx <= '0;
                r_nact <= (32'(r_pc) > MAX_FACES) ? CW'(MAX_FACES) : CW'(r_pc);
                o_res <= '{inside_res: 1'b0, in_box: in_box_c};
            end
            S_MUL: for (int c = 0; c < 3; c++)
                r_prod[c] <= r_rows[{r_row, 2'(c)}] * r_p[c];
            S_SUM: begin
                r_mp[r_row] <= sat_c;
                r_row <= r_row + 2'd1;
            end
            S_FACE: if (r_fidx != r_nact) r_fidx <= r_fidx + 1'b1;
            S_DONE: o_res.inside_res <= o_res.in_box & r_inside;
            default: ;
        endcase
        if (r_pend) begin
            r_fl <= w_rdata[192];
            r_dp[0] <= $signed(w_rdata[191:160])
                       * (33'(signed'(w_rdata[95:64])) - 33'(r_mp[0]));
            r_dp[1] <= $signed(w_rdata[159:128])
                       * (33'(signed'(w_rdata[63:32])) - 33'(r_mp[1]));
            r_dp[2] <= $signed(w_rdata[127:96])
                       * (33'(signed'(w_rdata[31:0])) - 33'(r_mp[2]));
        end
        if (r_dv && !r_fl && dot_c[67]) r_inside <= 1'b0;
    end

    a_strobe_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe |=> !o_res_strobe) else $error("double strobe");
    a_inside_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe && o_res.inside_res |-> o_res.in_box) else $error("inside w/o box");
    a_fidx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FACE |-> r_fidx <= r_nact) else $error("face index overrun");

endmodule

// ===== tb/sv/point_in_convex_polyhedron_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_in_convex_polyhedron_tb
// Self-checking bench for the convex polyhedron point test.
//
// A queue of requests feeds a burst-mode driver. Every accepted request
// updates a local copy of the transform, box and face stores, and each test
// request predicts the inside and in-box verdict, computed with exact wide
// sums. A monitor compares each result strobe with the oldest prediction.
// The face count is changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module point_in_convex_polyhedron_tb;
    import picp_pkg::*;

    localparam int Frac = 16;
    localparam int NumFaces = 64;
    localparam int CubeHalf = 4 << Frac;
    localparam int Unit = 1 << Frac;
    localparam logic signed [79:0] CoordMax = 80'sd2147483647;
    localparam logic signed [79:0] CoordMin = -80'sd2147483648;
    localparam int LimitCycles = 2000000;

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    t_req       i_req;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [6:0] i_cfg_data;
    logic       o_res_strobe;
    t_res       o_res;

    point_in_convex_polyhedron uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_res_strobe(o_res_strobe),
        .o_res       (o_res)
    );

    logic signed [31:0] row_store[12];
    logic signed [31:0] box_store[6];
    logic signed [31:0] normal_store[3*NumFaces];
    logic signed [31:0] vertex_store[3*NumFaces];
    bit                 flip_store[NumFaces];
    logic [6:0]         faces_active;

    t_req pending_requests[$];
    t_res expected_verdicts[$];
    int   fail_count;
    int   cycle_count;
    int   burst_left;
    int   gap_left;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Updates the local stores and, for a test request, predicts the verdict.
    task automatic apply_request(input t_req rq);
        logic signed [31:0] pt[3];
        logic signed [31:0] mp[3];
        logic signed [79:0] acc;
        logic signed [79:0] term;
        logic signed [79:0] diff;
        t_res verdict;
        int n;
        pt[0] = rq.val0;
        pt[1] = rq.val1;
        pt[2] = rq.val2;
        case (t_func'(rq.func))
            FUNC_ROW: begin
                if (rq.slot < 3) begin
                    row_store[rq.slot*4+0] = rq.val0;
                    row_store[rq.slot*4+1] = rq.val1;
                    row_store[rq.slot*4+2] = rq.val2;
                    row_store[rq.slot*4+3] = rq.val3;
                end
            end
            FUNC_BOX: begin
                box_store[0] = rq.val0;
                box_store[1] = rq.val1;
                box_store[2] = rq.val2;
                box_store[3] = rq.val3;
                box_store[4] = rq.val4;
                box_store[5] = rq.val5;
            end
            FUNC_FACE: begin
                normal_store[rq.slot*3+0] = rq.val0;
                normal_store[rq.slot*3+1] = rq.val1;
                normal_store[rq.slot*3+2] = rq.val2;
                vertex_store[rq.slot*3+0] = rq.val3;
                vertex_store[rq.slot*3+1] = rq.val4;
                vertex_store[rq.slot*3+2] = rq.val5;
                flip_store[rq.slot] = rq.flipped;
            end
            default: begin
                verdict.in_box = 1'b1;
                for (int i = 0; i < 3; i++) begin
                    if (pt[i] < box_store[i] || pt[i] > box_store[3+i]) begin
                        verdict.in_box = 1'b0;
                    end
                end
                verdict.inside_res = verdict.in_box;
                if (verdict.in_box) begin
                    for (int r = 0; r < 3; r++) begin
                        acc = 0;
                        for (int c = 0; c < 3; c++) begin
                            term = row_store[r*4+c];
                            acc = acc + term * pt[c];
                        end
                        term = row_store[r*4+3];
                        acc = acc + (term <<< Frac);
                        acc = acc >>> Frac;
                        if (acc > CoordMax) begin
                            mp[r] = 32'h7fffffff;
                        end else if (acc < CoordMin) begin
                            mp[r] = 32'h80000000;
                        end else begin
                            mp[r] = acc[31:0];
                        end
                    end
                    n = (faces_active > NumFaces) ? NumFaces : int'(faces_active);
                    for (int f = 0; f < n; f++) begin
                        if (!flip_store[f]) begin
                            acc = 0;
                            for (int c = 0; c < 3; c++) begin
                                diff = vertex_store[f*3+c];
                                term = mp[c];
                                diff = diff - term;
                                term = normal_store[f*3+c];
                                acc = acc + term * diff;
                            end
                            if (acc < 0) begin
                                verdict.inside_res = 1'b0;
                            end
                        end
                    end
                end
                expected_verdicts = {expected_verdicts, verdict};
            end
        endcase
    endtask

    task automatic queue_req(input t_func f, input int s, input int a, input int b,
                             input int c, input int d, input int e, input int g,
                             input bit fl);
        t_req rq;
        rq.func = f;
        rq.slot = s[5:0];
        rq.val0 = a;
        rq.val1 = b;
        rq.val2 = c;
        rq.val3 = d;
        rq.val4 = e;
        rq.val5 = g;
        rq.flipped = fl;
        pending_requests = {pending_requests, rq};
    endtask

    // One side of the cube; k below three is a positive side, otherwise negative.
    task automatic queue_cube_face(input int s, input int k, input int jit, input bit fl);
        int nv[3];
        int vv[3];
        int ax;
        int sg;
        ax = k % 3;
        sg = (k < 3) ? 1 : -1;
        for (int i = 0; i < 3; i++) begin
            nv[i] = 0;
            vv[i] = $urandom_range(0, 2 * Unit) - Unit;
        end
        nv[ax] = sg * Unit * $urandom_range(1, 4);
        vv[ax] = sg * (CubeHalf + jit);
        queue_req(FUNC_FACE, s, nv[0], nv[1], nv[2], vv[0], vv[1], vv[2], fl);
    endtask

    function automatic int near_value(input int span);
        return $urandom_range(0, 2 * span) - span;
    endfunction

    task automatic queue_near_rows();
        for (int r = 0; r < 3; r++) begin
            queue_req(FUNC_ROW, r,
                      (r == 0) ? Unit + near_value(Unit / 4) : near_value(Unit / 8),
                      (r == 1) ? Unit + near_value(Unit / 4) : near_value(Unit / 8),
                      (r == 2) ? Unit + near_value(Unit / 4) : near_value(Unit / 8),
                      near_value(Unit), 0, 0, 0);
        end
    endtask

    task automatic wait_idle();
        while (pending_requests.size() != 0 || start || expected_verdicts.size() != 0
               || busy) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_face_count(input logic [6:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        faces_active = value;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic queue_random_item();
        int pick;
        int lim;
        pick = $urandom_range(0, 99);
        lim = 3 * CubeHalf;
        if (pick < 58) begin
            queue_req(FUNC_TEST, $urandom, near_value(lim), near_value(lim), near_value(lim),
                      $urandom, $urandom, $urandom, $urandom_range(0, 1));
        end else if (pick < 64) begin
            queue_req(FUNC_TEST, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom_range(0, 1));
        end else if (pick < 68) begin
            queue_req(FUNC_TEST, 0, box_store[$urandom_range(0, 1) * 3],
                      box_store[1 + $urandom_range(0, 1) * 3],
                      box_store[2 + $urandom_range(0, 1) * 3], 0, 0, 0, 0);
        end else if (pick < 76) begin
            if ($urandom_range(0, 9) < 7) begin
                queue_near_rows();
            end else begin
                queue_req(FUNC_ROW, $urandom_range(0, 63), $urandom, $urandom, $urandom,
                          $urandom, $urandom, $urandom, $urandom_range(0, 1));
            end
        end else if (pick < 81) begin
            if ($urandom_range(0, 9) < 8) begin
                queue_req(FUNC_BOX, $urandom, -lim + near_value(Unit), -lim + near_value(Unit),
                          -lim + near_value(Unit), lim + near_value(Unit),
                          lim + near_value(Unit), lim + near_value(Unit), $urandom_range(0, 1));
            end else begin
                queue_req(FUNC_BOX, $urandom, 32'h80000000, 32'h80000000, 32'h80000000,
                          32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0);
            end
        end else begin
            if ($urandom_range(0, 4) != 0) begin
                queue_cube_face($urandom_range(0, 63), $urandom_range(0, 5),
                                near_value(Unit / 2), ($urandom_range(0, 5) == 0));
            end else begin
                queue_req(FUNC_FACE, $urandom_range(0, 63), $urandom, $urandom, $urandom,
                          $urandom, $urandom, $urandom, $urandom_range(0, 1));
            end
        end
    endtask

    // Request driver: bursts of requests separated by random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            burst_left <= 1;
            gap_left <= 0;
        end else begin
            if (start && !busy) begin
                apply_request(i_req);
            end
            if (start && busy) begin
                start <= 1'b1;
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                start <= 1'b0;
            end else if (pending_requests.size() != 0) begin
                i_req <= pending_requests.pop_front();
                start <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 30);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Result monitor.
    always @(posedge i_clk) begin
        if (i_rst_n && o_res_strobe) begin
            if (expected_verdicts.size() == 0) begin
                $error("Result with no request outstanding: inside_res %0b in_box %0b",
                       o_res.inside_res, o_res.in_box);
                fail_count++;
            end else begin
                t_res want;
                want = expected_verdicts.pop_front();
                if (o_res.inside_res !== want.inside_res) begin
                    $error("inside_res: expected %0b, actual %0b", want.inside_res,
                           o_res.inside_res);
                    fail_count++;
                end
                if (o_res.in_box !== want.in_box) begin
                    $error("in_box: expected %0b, actual %0b", want.in_box, o_res.in_box);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LimitCycles) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        logic [6:0] counts[8];
        counts = '{7'd0, 7'd6, 7'd64, 7'd127, 7'd1, 7'd65, 7'd0, 7'd0};
        counts[6] = $urandom_range(2, 63);
        counts[7] = $urandom_range(0, 127);
        fail_count = 0;
        cycle_count = 0;
        faces_active = 0;
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_req <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_face_count(7'd6);
        // Identity rows, a box around the cube, then every face slot written.
        for (int r = 0; r < 3; r++) begin
            queue_req(FUNC_ROW, r, (r == 0) ? Unit : 0, (r == 1) ? Unit : 0,
                      (r == 2) ? Unit : 0, 0, 0, 0, 0);
        end
        queue_req(FUNC_BOX, 0, -3 * CubeHalf, -3 * CubeHalf, -3 * CubeHalf,
                  3 * CubeHalf, 3 * CubeHalf, 3 * CubeHalf, 0);
        for (int f = 0; f < NumFaces; f++) begin
            queue_cube_face(f, f % 6, (f < 6) ? 0 : near_value(Unit / 2), (f >= 6) && f[0]);
        end
        wait_idle();

        // Directed part: centre, face touching, outside box, beyond a face.
        queue_req(FUNC_TEST, 0, 0, 0, 0, 0, 0, 0, 0);
        queue_req(FUNC_TEST, 63, CubeHalf, 0, 0, -1, -1, -1, 1);
        queue_req(FUNC_TEST, 0, CubeHalf + 1, 0, 0, 0, 0, 0, 0);
        queue_req(FUNC_TEST, 0, 0, -CubeHalf - Unit, 0, 0, 0, 0, 0);
        queue_req(FUNC_TEST, 0, 3 * CubeHalf, 3 * CubeHalf, -3 * CubeHalf, 0, 0, 0, 0);
        queue_req(FUNC_TEST, 0, 3 * CubeHalf + 1, 0, 0, 0, 0, 0, 0);
        queue_req(FUNC_TEST, 0, 0, 0, -3 * CubeHalf - 1, 0, 0, 0, 0);
        queue_req(FUNC_ROW, 3, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                  -1, -1, 1);
        queue_req(FUNC_ROW, 63, 0, 0, 0, 0, 0, 0, 0);
        queue_req(FUNC_TEST, 0, Unit, Unit, Unit, 0, 0, 0, 0);
        queue_req(FUNC_BOX, 0, 32'h80000000, 32'h80000000, 32'h80000000,
                  32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0);
        queue_req(FUNC_TEST, 0, 32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0, 0);
        queue_req(FUNC_TEST, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 0, 0, 0);
        queue_req(FUNC_ROW, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                  0, 0, 0);
        queue_req(FUNC_ROW, 1, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                  0, 0, 0);
        queue_req(FUNC_TEST, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 0, 0, 0);
        queue_req(FUNC_TEST, 0, 32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0, 0);
        queue_req(FUNC_TEST, 0, 32'h80000000, 32'h7fffffff, 0, 0, 0, 0, 0);
        queue_near_rows();
        queue_req(FUNC_TEST, 0, 0, 0, 0, 0, 0, 0, 0);
        wait_idle();

        for (int ph = 0; ph < 8; ph++) begin
            write_face_count(counts[ph]);
            for (int k = 0; k < 125; k++) begin
                queue_random_item();
            end
            wait_idle();
        end

        repeat (100) @(posedge i_clk);
        if (fail_count == 0 && expected_verdicts.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
